// ===== hw/rtl/smtp_reply_parser_defines.svh =====
// Assertion macros shared by the parser RTL.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef SMTP_REPLY_PARSER_DEFINES_SVH
`define SMTP_REPLY_PARSER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define SRP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle.
`define SRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/srp_pkg.sv =====
// ----------------------------------------------------------------------------
// SMTP reply parser package
// Types and constants shared by the parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CodeW  = 10;
  localparam int unsigned CountW = 2;
  localparam int unsigned StateW = 3;
  localparam int unsigned OutDataW = 24;

  // Parser states.
  localparam logic [StateW-1:0] ST_BEGIN  = 3'd0;
  localparam logic [StateW-1:0] ST_CODE   = 3'd1;
  localparam logic [StateW-1:0] ST_LAST   = 3'd2;
  localparam logic [StateW-1:0] ST_MIDDLE = 3'd3;
  localparam logic [StateW-1:0] ST_BAD    = 3'd4;

  // Characters of interest.
  localparam logic [ByteW-1:0] CH_TAB   = 8'h09;
  localparam logic [ByteW-1:0] CH_LF    = 8'h0A;
  localparam logic [ByteW-1:0] CH_CR    = 8'h0D;
  localparam logic [ByteW-1:0] CH_SPACE = 8'h20;
  localparam logic [ByteW-1:0] CH_DASH  = 8'h2D;
  localparam logic [ByteW-1:0] CH_ZERO  = 8'h30;
  localparam logic [ByteW-1:0] CH_NINE  = 8'h39;

  localparam logic [CountW-1:0] MAX_DIGITS = 2'd3;
  localparam logic [CodeW-1:0]  OK_LOW     = 10'd200;
  localparam logic [CodeW-1:0]  OK_HIGH    = 10'd300;

  typedef struct packed {
    logic [ByteW-1:0] text_byte;
    logic             text_valid;
    logic             line_end;
    logic             reply_done;
    logic [CodeW-1:0] reply_code;
    logic             reply_ok;
    logic             line_dropped;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/srp_in_stage.sv =====
// ----------------------------------------------------------------------------
// SMTP reply parser input stage
// Registers one received byte and hands it to the parser step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srp_in_stage (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [srp_pkg::ByteW-1:0] in_tdata,
  input  wire logic                     take,
  output logic                          s1_valid,
  output logic [srp_pkg::ByteW-1:0]     s1_byte
);
  import srp_pkg::*;

  logic             valid_r;
  logic             valid_nxt;
  logic [ByteW-1:0] byte_r;
  logic             load;

  // A new item may enter while the held one leaves in the same cycle.
  assign in_tready = !valid_r || take;
  assign load      = in_tvalid && in_tready;
  assign valid_nxt = load || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_tdata;
    end
  end

  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;

endmodule

`default_nettype wire

// ===== hw/rtl/srp_parse.sv =====
// ----------------------------------------------------------------------------
// SMTP reply parser step
// Holds the line state and decodes one byte into one result per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srp_parse (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      step_en,
  input  wire logic [srp_pkg::ByteW-1:0] rx_byte,
  output srp_pkg::res_t                  res
);
  import srp_pkg::*;

  `include "smtp_reply_parser_defines.svh"

  logic [StateW-1:0] state_r;
  logic [StateW-1:0] state_nxt;
  logic [CodeW-1:0]  code_r;
  logic [CodeW-1:0]  code_nxt;
  logic [CountW-1:0] count_r;
  logic [CountW-1:0] count_nxt;
  logic              is_digit;
  logic              is_space;
  logic [CodeW-1:0]  digit_val;
  logic [CodeW-1:0]  code_x10;
  logic              done;

  assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign is_space  = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
  assign digit_val = {{(CodeW-4){1'b0}}, 4'(rx_byte - CH_ZERO)};
  // Times ten as two shifts and an add, wrapping at the code width.
  assign code_x10  = {code_r[CodeW-4:0], 3'b000} + {code_r[CodeW-2:0], 1'b0};

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    count_nxt = count_r;
    res       = '0;
    done      = 1'b0;
    unique case (state_r)
      ST_CODE: begin
        if (is_digit) begin
          if (count_r == MAX_DIGITS) begin
            code_nxt  = '0;
            count_nxt = '0;
            state_nxt = ST_BAD;
          end else begin
            code_nxt  = code_x10 + digit_val;
            count_nxt = count_r + 2'd1;
          end
        end else if (rx_byte == CH_SPACE || rx_byte == CH_TAB || rx_byte == CH_CR) begin
          state_nxt = ST_LAST;
        end else if (rx_byte == CH_DASH) begin
          state_nxt = ST_MIDDLE;
        end else if (rx_byte == CH_LF) begin
          done      = 1'b1;
          state_nxt = ST_BEGIN;
        end else begin
          state_nxt = ST_BAD;
        end
      end
      ST_LAST, ST_MIDDLE: begin
        if (rx_byte == CH_LF) begin
          res.line_end = 1'b1;
          done         = (state_r == ST_LAST);
          state_nxt    = ST_BEGIN;
        end else begin
          res.text_valid = 1'b1;
          res.text_byte  = rx_byte;
        end
      end
      ST_BAD: begin
        if (rx_byte == CH_CR || rx_byte == CH_LF) begin
          res.line_dropped = 1'b1;
          state_nxt        = ST_BEGIN;
        end
      end
      default: begin
        // Start of line; unused encodings behave the same way.
        if (is_digit) begin
          code_nxt  = digit_val;
          count_nxt = 2'd1;
          state_nxt = ST_CODE;
        end else if (is_space) begin
          state_nxt = ST_BEGIN;
        end else begin
          code_nxt  = '0;
          count_nxt = '0;
          state_nxt = ST_BAD;
        end
      end
    endcase
    res.reply_done = done;
    if (done) begin
      res.reply_code = code_r;
      res.reply_ok   = (code_r >= OK_LOW) && (code_r < OK_HIGH);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_BEGIN;
      code_r  <= '0;
      count_r <= '0;
    end else if (step_en) begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
      count_r <= count_nxt;
    end
  end

  `SRP_ASSERT_NEXT(a_state_holds, !step_en, $stable(state_r) && $stable(code_r),
                   "parser state changed without a byte")
  `SRP_ASSERT_NEXT(a_bad_recovers,
                   step_en && state_r == ST_BAD && (rx_byte == CH_CR || rx_byte == CH_LF),
                   state_r == ST_BEGIN, "dropped line did not return to line start")
  `SRP_ASSERT_NEXT(a_fourth_digit,
                   step_en && state_r == ST_CODE && is_digit && count_r == MAX_DIGITS,
                   state_r == ST_BAD && code_r == '0, "overlong code not rejected")
  `SRP_ASSERT_SAME(a_code_lf_done, step_en && state_r == ST_CODE && rx_byte == CH_LF,
                   res.reply_done && !res.line_end, "code-only reply not reported")

endmodule

`default_nettype wire

// ===== hw/rtl/srp_out_stage.sv =====
// ----------------------------------------------------------------------------
// SMTP reply parser output stage
// Result register that holds one item until the consumer takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srp_out_stage (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           load_req,
  input  wire srp_pkg::res_t                  res,
  output logic                                advance,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [srp_pkg::OutDataW-1:0]        out_tdata,
  output logic                                out_tlast,
  output logic                                out_tuser
);
  import srp_pkg::*;

  logic valid_r;
  logic valid_nxt;
  res_t res_r;
  logic load;

  assign advance   = !valid_r || out_tready;
  assign load      = load_req && advance;
  assign valid_nxt = load || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tlast  = res_r.reply_done;
  assign out_tuser  = res_r.text_valid;
  assign out_tdata  = {3'b000, res_r.line_dropped, res_r.reply_ok, res_r.reply_code,
                       res_r.line_end, res_r.text_byte};

endmodule

`default_nettype wire

// ===== hw/rtl/smtp_reply_parser.sv =====
// Each byte passes the input register, the combinational parser step and the output register.
// One byte per cycle while out_tready stays high; parser state steps once per byte taken.
// in_tready follows out_tready combinationally; while a result waits, one more item
// fits in the input register, after which in_tready drops until the result is taken.
// Reset (rst_n low, synchronous): both stages empty, parser at line start, code and count zero.
// ----------------------------------------------------------------------------
// SMTP reply parser
// Byte-serial parser for SMTP server replies: echoes line text, reports codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smtp_reply_parser (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [srp_pkg::ByteW-1:0] in_tdata,   // [7:0] rx_byte
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  // [7:0] text_byte, [8] line_end, [18:9] reply_code, [19] reply_ok,
  // [20] line_dropped, [23:21] zero
  output logic [srp_pkg::OutDataW-1:0]   out_tdata,
  output logic                           out_tlast,  // reply_done
  output logic                           out_tuser   // text_valid
);
  import srp_pkg::*;

  logic             s1_valid;
  logic [ByteW-1:0] s1_byte;
  logic             advance;
  logic             take;
  res_t             res;

  assign take = s1_valid && advance;

  srp_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .take      (take),
    .s1_valid  (s1_valid),
    .s1_byte   (s1_byte)
  );

  srp_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (take),
    .rx_byte (s1_byte),
    .res     (res)
  );

  srp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_req   (s1_valid),
    .res        (res),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// ===== test/tb_smtp_reply_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SMTP reply parser testbench
// Streams reply bytes into the parser and checks every result item against a
// cycle-free model of the line syntax, under random stalls on both sides.
// ----------------------------------------------------------------------------

module tb_smtp_reply_parser;
  import srp_pkg::*;

  localparam int unsigned QuietLimit = 5000;
  localparam int unsigned PhaseItems = 617;
  localparam int unsigned TotalItems = 1850;
  localparam int unsigned ExpDepth   = 4096;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [ByteW-1:0]    in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tlast;
  logic                out_tuser;

  int unsigned in_idle_pct    = 0;
  int unsigned out_idle_pct   = 0;
  int unsigned bytes_sent     = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  // Mirror of the parser state, advanced once per accepted item.
  logic [StateW-1:0] line_state = ST_BEGIN;
  logic [CodeW-1:0]  code_acc   = '0;
  logic [CountW-1:0] digit_cnt  = '0;

  // Expected result items, written and read in order as a ring.
  res_t        exp_mem [ExpDepth];
  int unsigned exp_wr = 0;
  int unsigned exp_rd = 0;
  res_t        want;

  smtp_reply_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int unsigned pending();
    return exp_wr - exp_rd;
  endfunction

  function automatic bit is_num(input logic [ByteW-1:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  function automatic bit is_blank(input logic [ByteW-1:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic res_t step_parser(input logic [ByteW-1:0] b);
    res_t r;
    r = '0;
    case (line_state)
      ST_CODE: begin
        if (is_num(b)) begin
          if (digit_cnt >= MAX_DIGITS) begin
            code_acc   = '0;
            digit_cnt  = '0;
            line_state = ST_BAD;
          end else begin
            code_acc  = code_acc * 10'd10 + CodeW'(b - CH_ZERO);
            digit_cnt = digit_cnt + 2'd1;
          end
        end else if (b == CH_SPACE || b == CH_TAB || b == CH_CR) begin
          line_state = ST_LAST;
        end else if (b == CH_DASH) begin
          line_state = ST_MIDDLE;
        end else if (b == CH_LF) begin
          r.reply_done = 1'b1;
          r.reply_code = code_acc;
          line_state   = ST_BEGIN;
        end else begin
          line_state = ST_BAD;
        end
      end
      ST_LAST, ST_MIDDLE: begin
        if (b == CH_LF) begin
          r.line_end = 1'b1;
          if (line_state == ST_LAST) begin
            r.reply_done = 1'b1;
            r.reply_code = code_acc;
          end
          line_state = ST_BEGIN;
        end else begin
          r.text_valid = 1'b1;
          r.text_byte  = b;
        end
      end
      ST_BAD: begin
        if (b == CH_CR || b == CH_LF) begin
          r.line_dropped = 1'b1;
          line_state     = ST_BEGIN;
        end
      end
      default: begin
        if (is_num(b)) begin
          code_acc   = CodeW'(b - CH_ZERO);
          digit_cnt  = 2'd1;
          line_state = ST_CODE;
        end else if (is_blank(b)) begin
          line_state = ST_BEGIN;
        end else begin
          code_acc   = '0;
          digit_cnt  = '0;
          line_state = ST_BAD;
        end
      end
    endcase
    r.reply_ok = r.reply_done && r.reply_code >= OK_LOW && r.reply_code < OK_HIGH;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_val,
                                      input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      line_state = ST_BEGIN;
      code_acc   = '0;
      digit_cnt  = '0;
    end else if (in_tvalid && in_tready) begin
      exp_mem[exp_wr % ExpDepth] = step_parser(in_tdata);
      exp_wr++;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_wr == exp_rd) begin
        $error("result item with nothing expected: tdata %h", out_tdata);
        mismatch_count++;
      end else begin
        want = exp_mem[exp_rd % ExpDepth];
        exp_rd++;
        check_field("text_byte",    want.text_byte,    out_tdata[7:0]);
        check_field("text_valid",   want.text_valid,   out_tuser);
        check_field("line_end",     want.line_end,     out_tdata[8]);
        check_field("reply_done",   want.reply_done,   out_tlast);
        check_field("reply_code",   want.reply_code,   out_tdata[18:9]);
        check_field("reply_ok",     want.reply_ok,     out_tdata[19]);
        check_field("line_dropped", want.line_dropped, out_tdata[20]);
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  // Any cycle in which neither side moves an item counts towards the timeout.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("** smtp_reply_parser: FAILED **");
      $finish;
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_code(input int unsigned ndigits);
    repeat (ndigits) send_byte(CH_ZERO + ByteW'($urandom_range(0, 9)));
  endtask

  function automatic int unsigned code_len();
    return ($urandom_range(0, 9) < 7) ? 3 : $urandom_range(1, 2);
  endfunction

  task automatic send_blanks();
    logic [ByteW-1:0] b;
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 5))
        0:       b = CH_SPACE;
        1:       b = CH_TAB;
        2:       b = CH_LF;
        3:       b = CH_CR;
        4:       b = 8'h0B;
        default: b = 8'h0C;
      endcase
      send_byte(b);
    end
  endtask

  // Line text may hold any byte but LF, carriage returns included.
  task automatic send_line_text();
    logic [ByteW-1:0] b;
    repeat ($urandom_range(0, 6)) begin
      b = ByteW'($urandom_range(0, 255));
      if (b == CH_LF) b = CH_SPACE;
      send_byte(b);
    end
    if ($urandom_range(0, 1) == 1) send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  task automatic send_reply();
    logic [ByteW-1:0] sep;
    repeat ($urandom_range(0, 2)) begin
      send_blanks();
      send_code(code_len());
      send_byte(CH_DASH);
      send_line_text();
    end
    send_blanks();
    send_code(code_len());
    if ($urandom_range(0, 4) == 0) begin
      send_byte(CH_LF);
    end else begin
      case ($urandom_range(0, 2))
        0:       sep = CH_SPACE;
        1:       sep = CH_TAB;
        default: sep = CH_CR;
      endcase
      send_byte(sep);
      send_line_text();
    end
  endtask

  task automatic send_broken_line();
    logic [ByteW-1:0] b;
    case ($urandom_range(0, 2))
      0: send_code($urandom_range(4, 5));
      1: begin
        send_code(code_len());
        do b = ByteW'($urandom_range(0, 255));
        while (is_num(b) || b == CH_SPACE || b == CH_TAB || b == CH_CR ||
               b == CH_DASH || b == CH_LF);
        send_byte(b);
      end
      default: begin
        do b = ByteW'($urandom_range(0, 255));
        while (is_num(b) || is_blank(b));
        send_byte(b);
      end
    endcase
    repeat ($urandom_range(0, 4)) send_byte(ByteW'($urandom_range(0, 255)));
    send_byte(($urandom_range(0, 1) == 1) ? CH_CR : CH_LF);
  endtask

  task automatic test_line_start_extremes();
    send_byte(8'h00);
    send_byte(CH_LF);
  endtask

  task automatic test_last_line_text();
    send_byte(8'h0C);
    send_str("999");
    send_byte(CH_TAB);
    send_byte(8'hFF);
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  task automatic test_middle_then_code_only();
    send_str("2-\n250\n");
  endtask

  task automatic test_four_digit_code();
    send_str("1234\r");
  endtask

  task automatic test_bad_after_code();
    send_str("5x\n");
  endtask

  task automatic test_random_replies(input int unsigned target);
    int unsigned pick;
    while (bytes_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        send_reply();
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 8)) send_byte(ByteW'($urandom_range(0, 255)));
      end else begin
        send_broken_line();
      end
    end
  endtask

  task automatic test_drain_pause();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_pct  = 17;
    out_idle_pct = 65;
    test_line_start_extremes();
    test_last_line_text();
    test_middle_then_code_only();
    test_four_digit_code();
    test_bad_after_code();
    test_random_replies(PhaseItems);

    in_idle_pct  = 65;
    out_idle_pct = 17;
    test_random_replies(2 * PhaseItems);
    test_drain_pause();

    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random_replies(TotalItems);

    in_tvalid <= 1'b0;
    while (pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending() == 0) begin
      $display("** smtp_reply_parser: PASSED **");
    end else begin
      $display("** smtp_reply_parser: FAILED **");
    end
    $finish;
  end

endmodule
